/* rtl/core/npcl1_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcl1_pkg
// Shared types and constants for the nearest palette color (L1) core.
// ----------------------------------------------------------------------------
package npcl1_pkg;

   // palette geometry
   localparam int PALETTE_DEPTH = 1024;
   localparam int IDX_W         = $clog2(PALETTE_DEPTH);
   localparam int CNT_W         = 11;
   localparam int CH_W          = 8;
   localparam int PIX_W         = 3 * CH_W;

   // result arithmetic
   localparam int DIST_W       = 10;
   localparam int PCT_W        = 7;
   localparam int SUM_W        = 10;
   localparam int X_W          = 17;
   localparam int RECIP_W      = 12;
   localparam int RECIP_SHIFT  = 21;
   localparam int PROD_W       = X_W + RECIP_W;

   localparam logic [DIST_W-1:0]  MAX_L1     = DIST_W'(765);
   localparam logic [6:0]         PCT_SCALE  = 7'd100;
   localparam logic [SUM_W-1:0]   DARK_LIMIT = SUM_W'(500);
   // floor(2^21 / 765): estimate is low by at most one, fixed by one compare
   localparam logic [RECIP_W-1:0] PCT_RECIP  = RECIP_W'(2741);

   // request kinds carried in req_tuser
   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_QUERY = 1'b1
   } npcl1_req_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } npcl1_pixel_type;

   // sequencer to distance unit
   typedef struct packed {
      logic             clear;
      logic             hit;
      logic [IDX_W-1:0] idx;
   } npcl1_cmp_ctrl_type;

   // running best match
   typedef struct packed {
      logic              found;
      logic [IDX_W-1:0]  idx;
      logic [DIST_W-1:0] distance;
   } npcl1_best_type;

endpackage

/* rtl/core/npcl1_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcl1_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module npcl1_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/npcl1_dist.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcl1_dist
// Shared L1 distance and compare unit: one palette entry per cycle, keeps
// the best match, later entry wins on equal distance.
// ----------------------------------------------------------------------------
module npcl1_dist
   import npcl1_pkg::*;
(
   input  logic               clock,
   input  npcl1_cmp_ctrl_type ctrl,
   input  npcl1_pixel_type    query,
   input  npcl1_pixel_type    entry,
   output npcl1_best_type     best
);

   npcl1_best_type    best_ff;
   npcl1_best_type    best_in;
   logic [CH_W-1:0]   diff_r;
   logic [CH_W-1:0]   diff_g;
   logic [CH_W-1:0]   diff_b;
   logic [DIST_W-1:0] l1_dist;

   // per-channel absolute differences
   always_comb begin
      diff_r = (query.red >= entry.red) ? (query.red - entry.red)
                                        : (entry.red - query.red);
      diff_g = (query.green >= entry.green) ? (query.green - entry.green)
                                            : (entry.green - query.green);
      diff_b = (query.blue >= entry.blue) ? (query.blue - entry.blue)
                                          : (entry.blue - query.blue);
      l1_dist = DIST_W'(diff_r) + DIST_W'(diff_g) + DIST_W'(diff_b);
   end

   // best-match update
   always_comb begin
      best_in = best_ff;
      priority if (ctrl.clear) begin
         best_in = '0;
      end else if (ctrl.hit && (!best_ff.found || l1_dist <= best_ff.distance)) begin
         best_in.found    = 1'b1;
         best_in.idx      = ctrl.idx;
         best_in.distance = l1_dist;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
   end

   assign best = best_ff;

endmodule

/* rtl/core/nearest_palette_color_l1_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_l1_core
// Nearest palette color by L1 distance over a loadable RGB palette.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tuser[0] selects load (0) or query (1). A load writes the
//   pixel into palette slot entry_index and gives no result.
//   A query scans entries 0 .. entries_in_use-1 (saturated at the palette
//   depth) and returns one item on the rsp channel.
//   csr channel: writes entries_in_use; the user must write it only while
//   the core is idle, as the core itself does not enforce this.
//   Query flow: the palette RAM read port delivers one entry per cycle to a
//   single distance/compare unit for each scanned entry, followed by the
//   accuracy states (scale, reciprocal multiply, correction) and an output
//   state. req_tready is low for the whole query, so no new request is
//   taken until the query is done.
//   Output is registered: the core accepts and works on the next item while
//   a result waits. If the receiver stalls, a finished query holds in its
//   last step until the output register frees.
//   Reset clears control state and entries_in_use; palette contents are
//   undefined until loaded, and no clearing pass runs.
// ----------------------------------------------------------------------------
module nearest_palette_color_l1_core
   import npcl1_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // config
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CNT_W-1:0] csr_data,     // entries_in_use
   // request
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [39:0]      req_tdata,    // entry_index, red, green, blue, zero pad
   input  logic [0:0]       req_tuser,    // req_type
   // response
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [31:0]      rsp_tdata,    // best_index, best_distance,
                                          // accuracy_percent, dark_text, zero pad
   output logic [0:0]       rsp_tuser     // match_found
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SCAN = 6'b000010,
      ST_PCT1 = 6'b000100,
      ST_PCT2 = 6'b001000,
      ST_PCT3 = 6'b010000,
      ST_SEND = 6'b100000
   } npcl1_state_type;

   npcl1_state_type    state_ff, state_in;
   logic [CNT_W-1:0]   entries_ff, entries_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   addr_ff, addr_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   npcl1_pixel_type    pix_ff, pix_in;
   logic               dark_ff, dark_in;
   logic [X_W-1:0]     x_ff, x_in;
   logic [PCT_W-1:0]   q_ff, q_in;
   logic [PCT_W-1:0]   pct_ff, pct_in;
   logic               rsp_vld_ff, rsp_vld_in;
   npcl1_best_type     rsp_best_ff, rsp_best_in;
   logic [PCT_W-1:0]   rsp_pct_ff, rsp_pct_in;
   logic               rsp_dark_ff, rsp_dark_in;

   logic               req_fire;
   logic               rsp_fire;
   npcl1_req_type      req_kind;
   npcl1_pixel_type    req_pix;
   logic [IDX_W-1:0]   req_slot;
   logic [SUM_W-1:0]   req_sum;
   logic [CNT_W-1:0]   sat_count;
   logic               issue;
   logic               wr_en;
   logic [PIX_W-1:0]   rd_data;
   npcl1_cmp_ctrl_type cmp_ctrl;
   npcl1_best_type     best;
   logic [PROD_W-1:0]  recip_prod;
   logic [X_W-1:0]     q_times_max;
   logic [X_W-1:0]     rem;

   // request decode
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_kind   = npcl1_req_type'(req_tuser[0]);
   assign req_slot   = req_tdata[IDX_W-1:0];
   assign req_pix    = '{red: req_tdata[17:10], green: req_tdata[25:18],
                         blue: req_tdata[33:26]};
   assign req_sum    = SUM_W'(req_pix.red) + SUM_W'(req_pix.green)
                     + SUM_W'(req_pix.blue);
   assign sat_count  = (entries_ff > CNT_W'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH)
                                                          : entries_ff;
   assign wr_en      = req_fire && (req_kind == REQ_LOAD);
   assign csr_ready  = 1'b1;
   assign rsp_fire   = rsp_vld_ff && rsp_tready;

   // scan read issue
   assign issue = (state_ff == ST_SCAN) && (addr_ff < count_ff);

   npcl1_ram #(
      .WIDTH (PIX_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_slot),
      .wr_data (req_pix),
      .rd_en   (issue),
      .rd_addr (addr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign cmp_ctrl = '{clear: req_fire, hit: rd_vld_ff, idx: rd_idx_ff};

   npcl1_dist u_dist (
      .clock (clock),
      .ctrl  (cmp_ctrl),
      .query (pix_ff),
      .entry (npcl1_pixel_type'(rd_data)),
      .best  (best)
   );

   // accuracy arithmetic pieces
   assign recip_prod  = PROD_W'(x_ff) * PROD_W'(PCT_RECIP);
   assign q_times_max = X_W'(q_ff) * X_W'(MAX_L1);
   assign rem         = x_ff - q_times_max;

   // sequencer and datapath next values
   always_comb begin
      state_in    = state_ff;
      entries_in  = entries_ff;
      count_in    = count_ff;
      addr_in     = addr_ff;
      rd_vld_in   = issue;
      rd_idx_in   = addr_ff[IDX_W-1:0];
      pix_in      = pix_ff;
      dark_in     = dark_ff;
      x_in        = x_ff;
      q_in        = q_ff;
      pct_in      = pct_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_best_in = rsp_best_ff;
      rsp_pct_in  = rsp_pct_ff;
      rsp_dark_in = rsp_dark_ff;

      if (csr_valid && csr_ready) begin
         entries_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_kind == REQ_QUERY)) begin
               pix_in   = req_pix;
               dark_in  = (req_sum >= DARK_LIMIT);
               count_in = sat_count;
               addr_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               addr_in = addr_ff + CNT_W'(1);
            end else begin
               // last compare lands at this edge
               state_in = ST_PCT1;
            end
         end
         ST_PCT1: begin
            x_in     = X_W'(MAX_L1 - best.distance) * X_W'(PCT_SCALE);
            state_in = ST_PCT2;
         end
         ST_PCT2: begin
            q_in     = recip_prod[RECIP_SHIFT +: PCT_W];
            state_in = ST_PCT3;
         end
         ST_PCT3: begin
            pct_in   = (rem >= X_W'(MAX_L1)) ? (q_ff + PCT_W'(1)) : q_ff;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_best_in = best;
               rsp_pct_in  = best.found ? pct_ff : '0;
               rsp_dark_in = dark_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         entries_ff <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         entries_ff <= entries_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      addr_ff     <= addr_in;
      rd_idx_ff   <= rd_idx_in;
      pix_ff      <= pix_in;
      dark_ff     <= dark_in;
      x_ff        <= x_in;
      q_ff        <= q_in;
      pct_ff      <= pct_in;
      rsp_best_ff <= rsp_best_in;
      rsp_pct_ff  <= rsp_pct_in;
      rsp_dark_ff <= rsp_dark_in;
   end

   // response packing
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'b0, rsp_dark_ff, rsp_pct_ff, rsp_best_ff.distance,
                        rsp_best_ff.idx};
   assign rsp_tuser  = rsp_best_ff.found;

endmodule
